@@ src/tle_pkg.sv @@
package tle_pkg;

   typedef enum logic [1:0] {
      ACT_ECHO    = 2'd0,
      ACT_ERASE   = 2'd1,
      ACT_BELL    = 2'd2,
      ACT_NEWLINE = 2'd3
   } action_type;

   localparam logic [7:0] CH_ERASE = 8'h7F;
   localparam logic [7:0] CH_KILL  = 8'h15;
   localparam logic [7:0] CH_WORD  = 8'h17;
   localparam logic [7:0] CH_EOF   = 8'h04;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // White space for word erase: tab through carriage return, and space.
   function automatic logic is_blank(input logic [7:0] b);
      is_blank = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

endpackage

@@ src/terminal_line_editor_unit.sv @@
// Line editor for a character terminal: one typed byte per transfer in, terminal
// actions out.
//
// Channels: req_ carries one typed byte (req_in_byte) per transfer. rsp_ carries
// one terminal action per transfer: action code, echoed byte, session-over flag,
// and last, which marks the final action caused by one typed byte. Bytes that
// cause no action (erase, kill or word erase on an empty line, Ctrl-D on a
// non-empty line, anything after the session ended) are taken and dropped.
//
// Order: a single-action byte shows its result in the cycle after its transfer.
// Kill and word erase first enter their walk state, then give one erase per
// cycle while the receiver does not stall. The word erase walk is steered by the
// single line store, read through two registered ports at count-1 and count-2.
// Single-action bytes are taken back to back, one per cycle, unless stalled.
//
// Stall: one output register holds the pending action; while the receiver
// stalls, the walk and the input side hold. Reset clears the count, the
// session flag and the output valid; the line store is left as is.
module terminal_line_editor_unit #(
   parameter int LINE_CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_action,
   output logic [7:0]  rsp_echo_byte,
   output logic        rsp_session_over,
   output logic        rsp_last
);

   localparam int CNT_W = $clog2(LINE_CAPACITY + 1);
   localparam int IDX_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_KILL,
      S_WORD
   } state_type;

   // Line store and its two read ports.
   logic [7:0]       line_mem [LINE_CAPACITY];
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic [IDX_W-1:0] rd_cur_addr;
   logic [IDX_W-1:0] rd_prev_addr;
   logic [7:0]       rd_cur_ff;
   logic [7:0]       rd_prev_ff;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ended_ff, ended_in;
   logic             phase_ff, phase_in;

   logic             rsp_valid_ff, rsp_valid_in;
   tle_pkg::action_type rsp_action_ff, rsp_action_in;
   logic [7:0]       rsp_echo_byte_ff, rsp_echo_byte_in;
   logic             rsp_session_over_ff, rsp_session_over_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             can_emit;
   logic             accept;
   logic             cur_blank;
   logic             word_phase;

   assign can_emit  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && can_emit;
   assign accept    = req_valid && req_ready;
   assign cur_blank = tle_pkg::is_blank(rd_cur_ff);
   // Once a non-blank character is met, the walk is inside the word.
   assign word_phase = phase_ff || !cur_blank;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = rsp_action_ff;
   assign rsp_echo_byte    = rsp_echo_byte_ff;
   assign rsp_session_over = rsp_session_over_ff;
   assign rsp_last         = rsp_last_ff;

   always_comb begin
      state_in            = state_ff;
      count_in            = count_ff;
      ended_in            = ended_ff;
      phase_in            = phase_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_action_in       = rsp_action_ff;
      rsp_echo_byte_in    = rsp_echo_byte_ff;
      rsp_session_over_in = rsp_session_over_ff;
      rsp_last_in         = rsp_last_ff;
      wr_en               = 1'b0;
      wr_addr             = count_ff[IDX_W-1:0];
      wr_data             = req_in_byte;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && !ended_ff) begin
               rsp_echo_byte_in    = 8'h00;
               rsp_session_over_in = 1'b0;
               rsp_last_in         = 1'b1;
               if (req_in_byte == tle_pkg::CH_ERASE) begin
                  if (count_ff != '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_action_in = tle_pkg::ACT_ERASE;
                     count_in      = count_ff - CNT_W'(1);
                  end
               end else if (req_in_byte == tle_pkg::CH_KILL) begin
                  if (count_ff != '0) begin
                     state_in = S_KILL;
                  end
               end else if (req_in_byte == tle_pkg::CH_WORD) begin
                  if (count_ff != '0) begin
                     state_in = S_WORD;
                     phase_in = 1'b0;
                  end
               end else if (req_in_byte == tle_pkg::CH_EOF) begin
                  if (count_ff == '0) begin
                     rsp_valid_in        = 1'b1;
                     rsp_action_in       = tle_pkg::ACT_NEWLINE;
                     rsp_session_over_in = 1'b1;
                     ended_in            = 1'b1;
                  end
               end else if ((req_in_byte < tle_pkg::CH_SPACE) &&
                            (req_in_byte != tle_pkg::CH_NL) &&
                            (req_in_byte != tle_pkg::CH_TAB)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_action_in = tle_pkg::ACT_BELL;
               end else if (count_ff < CNT_W'(LINE_CAPACITY)) begin
                  // Store and echo.
                  wr_en            = 1'b1;
                  rsp_valid_in     = 1'b1;
                  rsp_action_in    = tle_pkg::ACT_ECHO;
                  rsp_echo_byte_in = req_in_byte;
                  count_in         = count_ff + CNT_W'(1);
               end else begin
                  // Line full: drop the byte and start a fresh line.
                  rsp_valid_in  = 1'b1;
                  rsp_action_in = tle_pkg::ACT_NEWLINE;
                  count_in      = '0;
               end
            end
         end
         S_KILL: begin
            if (can_emit) begin
               rsp_valid_in        = 1'b1;
               rsp_action_in       = tle_pkg::ACT_ERASE;
               rsp_echo_byte_in    = 8'h00;
               rsp_session_over_in = 1'b0;
               rsp_last_in         = (count_ff == CNT_W'(1));
               count_in            = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_WORD: begin
            // rd_cur_ff holds entry count-1, rd_prev_ff entry count-2.
            if (can_emit) begin
               rsp_valid_in        = 1'b1;
               rsp_action_in       = tle_pkg::ACT_ERASE;
               rsp_echo_byte_in    = 8'h00;
               rsp_session_over_in = 1'b0;
               rsp_last_in         = (count_ff == CNT_W'(1)) ||
                                     (word_phase && tle_pkg::is_blank(rd_prev_ff));
               count_in            = count_ff - CNT_W'(1);
               phase_in            = word_phase;
               if (rsp_last_in) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Read addresses follow the next count, so the read data lines up with it.
   assign rd_cur_addr  = (count_in != '0) ?
                         IDX_W'(count_in - CNT_W'(1)) : '0;
   assign rd_prev_addr = (count_in > CNT_W'(1)) ?
                         IDX_W'(count_in - CNT_W'(2)) : '0;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      // Forward a write to the same entry in this cycle.
      if (wr_en && (wr_addr == rd_cur_addr)) begin
         rd_cur_ff <= wr_data;
      end else begin
         rd_cur_ff <= line_mem[rd_cur_addr];
      end
      if (wr_en && (wr_addr == rd_prev_addr)) begin
         rd_prev_ff <= wr_data;
      end else begin
         rd_prev_ff <= line_mem[rd_prev_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ended_ff     <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ended_ff     <= ended_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_action_ff       <= rsp_action_in;
      rsp_echo_byte_ff    <= rsp_echo_byte_in;
      rsp_session_over_ff <= rsp_session_over_in;
      rsp_last_ff         <= rsp_last_in;
   end

endmodule

@@ src/tle_checker.sv @@
module tle_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_action,
   input logic [7:0] rsp_echo_byte,
   input logic       rsp_session_over,
   input logic       rsp_last
);

   // Hold a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action) &&
      $stable(rsp_echo_byte) && $stable(rsp_session_over) && $stable(rsp_last))
      else $error("stalled result changed");

   // Only an echo carries a byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action != tle_pkg::ACT_ECHO) |-> rsp_echo_byte == 8'h00)
      else $error("echo byte set on a non-echo action");

   // Session end is a lone newline.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_session_over |-> (rsp_action == tle_pkg::ACT_NEWLINE) && rsp_last)
      else $error("session end on a wrong action");

   // Nothing follows the end of the session.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_session_over |=> !rsp_valid)
      else $error("result after session end");

endmodule

bind terminal_line_editor_unit tle_checker u_tle_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_action       (rsp_action),
   .rsp_echo_byte    (rsp_echo_byte),
   .rsp_session_over (rsp_session_over),
   .rsp_last         (rsp_last)
);
